FILE: rtl/wpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_pkg: shared types and constants of the WAVE PCM stream parser
// Parse phases, result kinds, error codes, header offsets and the word types
// passed between the input stage, the parser core and the result stage.
// ----------------------------------------------------------------------------
package wpp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SEARCH,
        PH_SIZE,
        PH_SAMPLES,
        PH_DONE
    } phase_t;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
    localparam logic [2:0] ERR_FMT_SIZE    = 3'd1;
    localparam logic [2:0] ERR_COMPRESSED  = 3'd2;
    localparam logic [2:0] ERR_NO_CHANNELS = 3'd3;
    localparam logic [2:0] ERR_BAD_WIDTH   = 3'd4;

    localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
    localparam logic [31:0] DATA_TAG = 32'h6174_6164;

    localparam int          OFF_W       = 6;
    localparam logic [5:0]  OFF_TAG_END = 6'd3;
    localparam logic [5:0]  HDR_LAST    = 6'd35;

    localparam logic [31:0] FMT_PCM_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] WIDTH_8      = 16'd8;
    localparam logic [15:0] WIDTH_16     = 16'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_value;
        logic [15:0]        channel_index;
        logic               last_sample;
        logic [15:0]        channels;
        logic [31:0]        rate_hz;
        logic [15:0]        sample_bits;
        logic [31:0]        data_bytes;
        logic [2:0]         error_code;
    } result_t;

endpackage

FILE: rtl/wpp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_in_stage: input register
// Captures one byte word from the input channel and holds it until the
// parser core takes it.
// ----------------------------------------------------------------------------
module wpp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              file_start,
    input  logic              take,
    output logic              item_valid,
    output wpp_pkg::in_item_t item
);
    import wpp_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data_byte  <= data_byte;
            item_reg.file_start <= file_start;
        end
    end

endmodule

FILE: rtl/wpp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_core: RIFF/WAVE parser state and per-byte decode
// Walks the header, the fmt checks, the data tag search and the data size, then
// turns data bytes into Q1.15 samples. One byte per cycle, unless results wait.
// ----------------------------------------------------------------------------
module wpp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  wpp_pkg::in_item_t item,
    input  logic              slot_free,
    output logic              take,
    output logic              res_valid,
    output wpp_pkg::result_t  res
);
    import wpp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [31:0]       window_reg, window_next;
    logic [31:0]       fmt_size_reg, fmt_size_next;
    logic [15:0]       format_reg, format_next;
    logic [15:0]       chan_total_reg, chan_total_next;
    logic [31:0]       rate_reg, rate_next;
    logic [15:0]       bits_reg, bits_next;
    logic [31:0]       size_reg, size_next;
    logic [1:0]        size_idx_reg, size_idx_next;
    logic [31:0]       consumed_reg, consumed_next;
    logic [7:0]        hold_reg, hold_next;
    logic [15:0]       chan_reg, chan_next;

    phase_t            cur_phase;
    logic [OFF_W-1:0]  cur_off;
    logic [7:0]        b;
    logic [31:0]       tag_word;
    logic [15:0]       bits_full;
    logic              tag_bad;
    logic              hdr_bad;
    logic [2:0]        hdr_code;
    logic              data_hit;
    logic              size_done;
    logic [31:0]       size_full;
    logic [31:0]       need_bytes;
    logic              is8;
    logic [31:0]       usable;
    logic [31:0]       consumed_inc;
    logic              samp_hold;
    logic              samp_last;
    logic [15:0]       chan_inc;

    assign b         = item.data_byte;
    assign cur_phase = item.file_start ? PH_HEADER : phase_reg;
    assign cur_off   = item.file_start ? '0 : off_reg;

    assign tag_word  = {b, window_reg[23:0]};
    assign tag_bad   = (cur_off == OFF_TAG_END) && (tag_word != RIFF_TAG);
    assign bits_full = {b, bits_reg[7:0]};

    // fmt checks in priority order, first failure wins
    always_comb
    begin
        hdr_bad  = 1'b1;
        hdr_code = ERR_FMT_SIZE;
        if (fmt_size_reg != FMT_PCM_SIZE)
        begin
            hdr_code = ERR_FMT_SIZE;
        end
        else if (format_reg != FMT_PCM)
        begin
            hdr_code = ERR_COMPRESSED;
        end
        else if (chan_total_reg == 16'd0)
        begin
            hdr_code = ERR_NO_CHANNELS;
        end
        else if (bits_full != WIDTH_8 && bits_full != WIDTH_16)
        begin
            hdr_code = ERR_BAD_WIDTH;
        end
        else
        begin
            hdr_bad = 1'b0;
        end
    end

    assign data_hit   = {b, window_reg[31:8]} == DATA_TAG;
    assign size_done  = size_idx_reg == 2'd3;
    assign size_full  = {b, size_reg[23:0]};
    assign need_bytes = {19'd0, bits_reg[15:3]};

    assign is8          = bits_reg == WIDTH_8;
    assign usable       = is8 ? size_reg : {size_reg[31:1], 1'b0};
    assign consumed_inc = consumed_reg + 32'd1;
    assign samp_hold    = !is8 && !consumed_reg[0];
    assign samp_last    = consumed_inc >= usable;
    assign chan_inc     = chan_reg + 16'd1;

    // next phase
    always_comb
    begin
        phase_next = cur_phase;
        case (cur_phase)
            PH_HEADER:
            begin
                if (tag_bad)
                begin
                    phase_next = PH_DONE;
                end
                else if (cur_off == HDR_LAST)
                begin
                    phase_next = hdr_bad ? PH_DONE : PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (data_hit)
                begin
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (size_done)
                begin
                    phase_next = (size_full >= need_bytes) ? PH_SAMPLES : PH_DONE;
                end
            end
            PH_SAMPLES:
            begin
                if (!samp_hold && samp_last)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // datapath updates and result word
    always_comb
    begin
        off_next        = off_reg;
        window_next     = window_reg;
        fmt_size_next   = fmt_size_reg;
        format_next     = format_reg;
        chan_total_next = chan_total_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        size_next       = size_reg;
        size_idx_next   = size_idx_reg;
        consumed_next   = consumed_reg;
        hold_next       = hold_reg;
        chan_next       = chan_reg;
        res_valid       = 1'b0;
        res             = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                off_next = cur_off + 6'd1;
                if (cur_off inside {[6'd0:6'd3]})
                begin
                    window_next[8*cur_off[1:0] +: 8] = b;
                end
                else if (cur_off inside {[6'd16:6'd19]})
                begin
                    fmt_size_next[8*cur_off[1:0] +: 8] = b;
                end
                else if (cur_off inside {6'd20, 6'd21})
                begin
                    format_next[8*cur_off[0] +: 8] = b;
                end
                else if (cur_off inside {6'd22, 6'd23})
                begin
                    chan_total_next[8*cur_off[0] +: 8] = b;
                end
                else if (cur_off inside {[6'd24:6'd27]})
                begin
                    rate_next[8*cur_off[1:0] +: 8] = b;
                end
                else if (cur_off inside {6'd34, 6'd35})
                begin
                    bits_next[8*cur_off[0] +: 8] = b;
                end

                if (tag_bad)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NOT_RIFF;
                end
                else if (cur_off == HDR_LAST)
                begin
                    window_next = '0;
                    if (hdr_bad)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = hdr_code;
                    end
                end
            end
            PH_SEARCH:
            begin
                window_next = {b, window_reg[31:8]};
                if (data_hit)
                begin
                    size_idx_next = 2'd0;
                    size_next     = '0;
                end
            end
            PH_SIZE:
            begin
                size_next[8*size_idx_reg +: 8] = b;
                size_idx_next                  = size_idx_reg + 2'd1;
                if (size_done)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_HEADER;
                    res.channels    = chan_total_reg;
                    res.rate_hz     = rate_reg;
                    res.sample_bits = bits_reg;
                    res.data_bytes  = size_full;
                    consumed_next   = '0;
                    chan_next       = '0;
                end
            end
            PH_SAMPLES:
            begin
                consumed_next = consumed_inc;
                if (samp_hold)
                begin
                    hold_next = b;
                end
                else
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_SAMPLE;
                    res.sample_value  = is8 ? {~b[7], b[6:0], 8'd0} : {b, hold_reg};
                    res.channel_index = chan_reg;
                    res.last_sample   = samp_last;
                    chan_next         = (chan_inc >= chan_total_reg) ? 16'd0 : chan_inc;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // a word that makes a result waits for a free result slot
    assign take = item_valid && (!res_valid || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            off_reg        <= off_next;
            window_reg     <= window_next;
            fmt_size_reg   <= fmt_size_next;
            format_reg     <= format_next;
            chan_total_reg <= chan_total_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            size_reg       <= size_next;
            size_idx_reg   <= size_idx_next;
            consumed_reg   <= consumed_next;
            hold_reg       <= hold_next;
            chan_reg       <= chan_next;
        end
    end

    hdr_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> off_reg <= HDR_LAST)
        else $error("header offset ran past the fmt chunk");

    chan_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SAMPLES |-> chan_reg < chan_total_reg)
        else $error("channel counter outside the frame");

    width_checked: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SAMPLES |-> (bits_reg == WIDTH_8 || bits_reg == WIDTH_16))
        else $error("sample phase with an unchecked sample width");

    last_ends_data: assert property (@(posedge clk) disable iff (!rst_n)
        take && res_valid && res.kind == KIND_SAMPLE && res.last_sample
        |=> phase_reg == PH_DONE)
        else $error("parser kept going after the last sample");

endmodule

FILE: rtl/wpp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpp_out_stage: result register
// Holds one result word for the output channel and reports whether a new
// word can be loaded in this cycle.
// ----------------------------------------------------------------------------
module wpp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  wpp_pkg::result_t res,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output wpp_pkg::result_t held
);
    import wpp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign held      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: rtl/wav_pcm_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser: RIFF/WAVE PCM byte stream parser
// Takes a WAVE file one byte per word and returns a header word, an error
// word, or interleaved Q1.15 samples with channel index and last mark.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle unless input stalls as described
// below. A byte word sits in the input register, where the parser core
// decodes it against its phase and header fields, and its result (if any) is
// loaded into the result register when the core takes the byte; out_valid
// rises with that load. The result register and the input register let a new
// byte enter while a result waits; input stalls only when both registers are
// full, the waiting byte makes a result and out_ready is low. Assert
// file_start with the first byte of every file; bytes before it, after an
// error, and after the data chunk are dropped.
module wav_pcm_stream_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               file_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic signed [15:0] sample_value,
    output logic [15:0]        channel_index,
    output logic               last_sample,
    output logic [15:0]        channels,
    output logic [31:0]        rate_hz,
    output logic [15:0]        sample_bits,
    output logic [31:0]        data_bytes,
    output logic [2:0]         error_code
);
    import wpp_pkg::*;

    logic     take;
    logic     item_valid;
    in_item_t item;
    logic     slot_free;
    logic     res_valid;
    result_t  res;
    result_t  held;

    wpp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .file_start (file_start),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    wpp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .slot_free  (slot_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    wpp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign kind          = held.kind;
    assign sample_value  = held.sample_value;
    assign channel_index = held.channel_index;
    assign last_sample   = held.last_sample;
    assign channels      = held.channels;
    assign rate_hz       = held.rate_hz;
    assign sample_bits   = held.sample_bits;
    assign data_bytes    = held.data_bytes;
    assign error_code    = held.error_code;

endmodule
